FILE: src/crt_pkg.sv
// Shared constants, types and helper functions for the countdown relay timer.
package crt_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_SCALE        = 3'd0;
	localparam logic [2:0] REG_DEBOUNCE     = 3'd1;
	localparam logic [2:0] REG_TICKS_PER_S  = 3'd2;
	localparam logic [2:0] REG_INITIAL_LOW  = 3'd3;
	localparam logic [2:0] REG_INITIAL_HIGH = 3'd4;

	// Reset values of the configuration registers
	localparam logic [7:0] SCALE_RST        = 8'd5;
	localparam logic [3:0] DEBOUNCE_RST     = 4'd4;
	localparam logic [7:0] TICKS_PER_S_RST  = 8'd20;
	localparam logic [3:0] INITIAL_LOW_RST  = 4'd0;
	localparam logic [3:0] INITIAL_HIGH_RST = 4'd6;

	// Operating mode codes, as seen on the mode output
	localparam logic [2:0] MODE_READY   = 3'd0;
	localparam logic [2:0] MODE_EDIT_LO = 3'd1;
	localparam logic [2:0] MODE_EDIT_HI = 3'd2;
	localparam logic [2:0] MODE_ARMING  = 3'd3;
	localparam logic [2:0] MODE_COUNT   = 3'd4;

	localparam int          CNT_W     = 15;
	localparam logic [7:0]  DOT_MASK  = 8'hFE;
	localparam logic [3:0]  DIGIT_MAX = 4'd9;
	localparam logic [6:0]  SHOW_MAX  = 7'd99;

	// Debounce counter width
	localparam int SKIP_W = 4;

	// Active-low segment patterns, dot in bit 0 left dark here
	function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
		logic [7:0] p;
		begin
			case (digit)
				4'd0: p = 8'h09;
				4'd1: p = 8'hAF;
				4'd2: p = 8'h31;
				4'd3: p = 8'h23;
				4'd4: p = 8'h87;
				4'd5: p = 8'h43;
				4'd6: p = 8'h41;
				4'd7: p = 8'h2F;
				4'd8: p = 8'h01;
				default: p = 8'h03;
			endcase
			return p;
		end
	endfunction

	// Saturate a raw nibble to a decimal digit
	function automatic logic [3:0] clamp9(input logic [3:0] v);
		return (v > DIGIT_MAX) ? DIGIT_MAX : v;
	endfunction

	// Tens digit of a value up to 99, by multiply with 205/2048
	function automatic logic [3:0] tens_of(input logic [6:0] t);
		logic [14:0] prod;
		begin
			prod = 15'(t) * 15'd205;
			return prod[14:11];
		end
	endfunction

	// Control bundle from the sequencer into the divider
	typedef struct packed {
		logic              start;
		logic [CNT_W-1:0]  dividend;
		logic [7:0]        divisor;
	} div_req_t;

	// Status bundle from the divider back to the sequencer
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [CNT_W-1:0]  quotient;
	} div_rsp_t;

endpackage

FILE: src/countdown_relay_timer.sv
// Top level of the countdown relay timer: registers, mode machine, sequencer, display.
//
// Usage: each transfer on the input channel (in_valid/in_ready) is one display
// scan tick carrying the two raw button levels and a timebase pulse. Each tick
// yields exactly one transfer on the output channel (out_valid/out_ready):
// the active-low segment byte and digit select for the scanned digit, the
// relay drive, the mode code and the seconds left.
// Most ticks pass from the accepting edge straight to the emit step; a tick at a
// second boundary that keeps timing, with a nonzero scale, first waits in the
// divide step, as the shown value comes from a 15-step shift-subtract divider
// (one quotient bit per cycle). in_ready is high only while the sequencer is idle,
// so ticks are taken one at a time. The result sits in an output register: a new
// tick is accepted while it waits and held in the emit step until the receiver
// takes the earlier result. Reset: mode ready, setting 60, scale 5, debounce 4, 20
// pulses per second, no result pending. Registers are to be written by the user
// over the APB port only while idle; the block itself does not enforce this.
module countdown_relay_timer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [4:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        button_a_down,
	input  logic                        button_b_down,
	input  logic                        timebase_tick,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  segments,
	output logic                        digit_select,
	output logic                        relay_on,
	output logic [2:0]                  mode,
	output logic [crt_pkg::CNT_W-1:0]   remaining
);
	import crt_pkg::*;

	typedef enum logic [2:0] {
		SEQ_IDLE = 3'b001,
		SEQ_DIV  = 3'b010,
		SEQ_EMIT = 3'b100
	} seq_t;

	seq_t             seq_q;
	logic [7:0]       scale_q;
	logic [3:0]       debounce_q;
	logic [7:0]       tps_q;
	logic [3:0]       init_low_q;
	logic [3:0]       init_high_q;
	logic [2:0]       mode_q;
	logic [3:0]       set_low_q;
	logic [3:0]       set_high_q;
	logic [CNT_W-1:0] secs_q;
	logic [3:0]       shown_q [2];
	logic             scan_q;
	logic [7:0]       pc_q;
	logic             flag_q;

	logic             cfg_wr;
	logic [2:0]       cfg_idx;
	logic [3:0]       wr_digit;
	logic             accept;
	logic             press_a;
	logic             press_b;
	logic             take_a;
	logic             take_b;

	logic [2:0]       mode_n;
	logic [3:0]       set_low_n;
	logic [3:0]       set_high_n;
	logic [CNT_W-1:0] secs_n;
	logic [3:0]       shown0_n;
	logic [3:0]       shown1_n;
	logic [7:0]       pc_n;
	logic             flag_n;
	logic             need_div;
	logic [CNT_W-1:0] after_val;
	logic [8:0]       pc_inc;
	logic [6:0]       setting;

	div_req_t         div_req;
	div_rsp_t         div_rsp;
	logic [6:0]       shown_t;
	logic [3:0]       t_tens;
	logic [6:0]       t_units;

	logic             pos;
	logic             dot;
	logic [7:0]       seg_raw;

	// Configuration port
	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign cfg_idx  = paddr[4:2];
	assign wr_digit = clamp9(pwdata[3:0]);

	always_comb begin
		case (cfg_idx)
			REG_SCALE:        prdata = 32'(scale_q);
			REG_DEBOUNCE:     prdata = 32'(debounce_q);
			REG_TICKS_PER_S:  prdata = 32'(tps_q);
			REG_INITIAL_LOW:  prdata = 32'(init_low_q);
			REG_INITIAL_HIGH: prdata = 32'(init_high_q);
			default:          prdata = '0;
		endcase
	end

	assign in_ready = (seq_q == SEQ_IDLE);
	assign accept   = in_valid & in_ready;

	// Button debouncers
	crt_debounce u_deb_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (accept),
		.down     (button_a_down),
		.skip_cfg (debounce_q),
		.take     (take_a),
		.pressed  (press_a)
	);

	crt_debounce u_deb_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (accept),
		.down     (button_b_down),
		.skip_cfg (debounce_q),
		.take     (take_b),
		.pressed  (press_b)
	);

	assign pc_inc  = 9'(pc_q) + 9'd1;
	assign setting = 7'(set_high_q) * 7'd10 + 7'(set_low_q);

	// Prescaler and one pass of the mode machine
	always_comb begin
		pc_n       = pc_q;
		flag_n     = flag_q;
		mode_n     = mode_q;
		set_low_n  = set_low_q;
		set_high_n = set_high_q;
		secs_n     = secs_q;
		shown0_n   = shown_q[0];
		shown1_n   = shown_q[1];
		take_a     = 1'b0;
		take_b     = 1'b0;
		need_div   = 1'b0;
		after_val  = secs_q;

		if (timebase_tick) begin
			if (pc_inc >= 9'(tps_q)) begin
				pc_n   = '0;
				flag_n = 1'b1;
			end else begin
				pc_n = pc_inc[7:0];
			end
		end

		case (mode_q)
			MODE_READY: begin
				shown0_n = set_low_q;
				shown1_n = set_high_q;
				if (press_a) begin
					take_a = 1'b1;
					mode_n = MODE_ARMING;
					secs_n = CNT_W'(15'(setting) * 15'(scale_q));
				end else if (press_b) begin
					take_b = 1'b1;
					mode_n = MODE_EDIT_LO;
				end
			end
			MODE_EDIT_LO: begin
				if (press_a) begin
					take_a    = 1'b1;
					set_low_n = (set_low_q >= DIGIT_MAX) ? 4'd0 : set_low_q + 4'd1;
					shown0_n  = set_low_n;
				end else if (press_b) begin
					take_b = 1'b1;
					mode_n = MODE_EDIT_HI;
				end
			end
			MODE_EDIT_HI: begin
				if (press_a) begin
					take_a     = 1'b1;
					set_high_n = (set_high_q >= DIGIT_MAX) ? 4'd0 : set_high_q + 4'd1;
					shown1_n   = set_high_n;
				end else if (press_b) begin
					take_b   = 1'b1;
					mode_n   = MODE_READY;
					secs_n   = '0;
					shown0_n = set_low_q;
					shown1_n = set_high_q;
				end
			end
			MODE_ARMING, MODE_COUNT: begin
				if (flag_n) begin
					flag_n = 1'b0;
					if (mode_q == MODE_COUNT && secs_q != '0) begin
						after_val = secs_q - 1'b1;
					end
					secs_n = after_val;
					if (after_val == '0 || press_a) begin
						take_a   = press_a && (after_val != '0);
						mode_n   = MODE_READY;
						secs_n   = '0;
						shown0_n = set_low_q;
						shown1_n = set_high_q;
					end else begin
						mode_n = MODE_COUNT;
						if (scale_q == '0) begin
							shown0_n = DIGIT_MAX;
							shown1_n = DIGIT_MAX;
						end else begin
							need_div = 1'b1;
						end
					end
				end
			end
			default: begin
				mode_n   = MODE_READY;
				secs_n   = '0;
				shown0_n = set_low_q;
				shown1_n = set_high_q;
			end
		endcase
	end

	// Divider hookup
	assign div_req.start    = accept & need_div;
	assign div_req.dividend = after_val;
	assign div_req.divisor  = scale_q;

	crt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Saturate the quotient to 99 and split into digits
	assign shown_t = (div_rsp.quotient > CNT_W'(SHOW_MAX)) ? SHOW_MAX : div_rsp.quotient[6:0];
	assign t_tens  = tens_of(shown_t);
	assign t_units = shown_t - 7'(t_tens) * 7'd10;

	// Configuration registers and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q      <= SCALE_RST;
			debounce_q   <= DEBOUNCE_RST;
			tps_q        <= TICKS_PER_S_RST;
			init_low_q   <= INITIAL_LOW_RST;
			init_high_q  <= INITIAL_HIGH_RST;
			mode_q       <= MODE_READY;
			set_low_q    <= INITIAL_LOW_RST;
			set_high_q   <= INITIAL_HIGH_RST;
			secs_q       <= '0;
			shown_q[0]   <= INITIAL_LOW_RST;
			shown_q[1]   <= INITIAL_HIGH_RST;
			pc_q         <= '0;
			flag_q       <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SCALE:       scale_q      <= pwdata[7:0];
				REG_DEBOUNCE:    debounce_q   <= pwdata[3:0];
				REG_TICKS_PER_S: tps_q        <= pwdata[7:0];
				REG_INITIAL_LOW: begin
					init_low_q <= wr_digit;
					set_low_q  <= wr_digit;
					if (mode_q < MODE_ARMING) begin
						shown_q[0] <= wr_digit;
					end
				end
				REG_INITIAL_HIGH: begin
					init_high_q <= wr_digit;
					set_high_q  <= wr_digit;
					if (mode_q < MODE_ARMING) begin
						shown_q[1] <= wr_digit;
					end
				end
				default: ;
			endcase
		end else if (accept) begin
			mode_q     <= mode_n;
			set_low_q  <= set_low_n;
			set_high_q <= set_high_n;
			secs_q     <= secs_n;
			shown_q[0] <= shown0_n;
			shown_q[1] <= shown1_n;
			pc_q       <= pc_n;
			flag_q     <= flag_n;
		end else if (div_rsp.done) begin
			shown_q[0] <= t_units[3:0];
			shown_q[1] <= t_tens;
		end
	end

	// Sequencer: idle, wait on the divider, emit the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
		end else begin
			case (seq_q)
				SEQ_IDLE: begin
					if (accept) begin
						seq_q <= need_div ? SEQ_DIV : SEQ_EMIT;
					end
				end
				SEQ_DIV: begin
					if (div_rsp.done) begin
						seq_q <= SEQ_EMIT;
					end
				end
				SEQ_EMIT: begin
					if (!out_valid || out_ready) begin
						seq_q <= SEQ_IDLE;
					end
				end
				default: seq_q <= SEQ_IDLE;
			endcase
		end
	end

	// Digit drive for the scanned position
	assign pos = scan_q;
	always_comb begin
		case (mode_q)
			MODE_READY:   dot = 1'b1;
			MODE_EDIT_LO: dot = (pos == 1'b0);
			MODE_EDIT_HI: dot = (pos == 1'b1);
			default:      dot = 1'b0;
		endcase
	end
	assign seg_raw = seg_pattern(clamp9(shown_q[pos]));

	// Output register: load on emit once the previous transfer is gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			scan_q    <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (seq_q == SEQ_EMIT && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
				scan_q    <= ~scan_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == SEQ_EMIT && (!out_valid || out_ready)) begin
			segments     <= dot ? (seg_raw & DOT_MASK) : (seg_raw | 8'h01);
			digit_select <= pos;
			relay_on     <= (mode_q >= MODE_ARMING);
			mode         <= mode_q;
			remaining    <= (mode_q >= MODE_ARMING) ? secs_q : '0;
		end
	end

`ifndef SYNTH
	// Divider runs only while the sequencer waits on it
	a_div_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> seq_q == SEQ_DIV)
		else $error("divider busy outside its sequencer step");

	// An accepted tick keeps in_ready low in the cycle after it
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second tick accepted while one is in work");

	// Relay drive agrees with the reported mode
	a_relay_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> relay_on == (mode == MODE_ARMING || mode == MODE_COUNT))
		else $error("relay drive disagrees with mode");

	// Seconds left reads zero when not timing
	a_remaining_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !relay_on) |-> remaining == '0)
		else $error("nonzero remaining outside timing");

	// Mode register holds a defined code
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= MODE_COUNT)
		else $error("mode register out of range");
`endif

endmodule

FILE: src/crt_debounce.sv
// Skip-counter debouncer with a press latch for one button.
module crt_debounce (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic                      down,
	input  logic [crt_pkg::SKIP_W-1:0] skip_cfg,
	input  logic                      take,
	output logic                      pressed
);
	import crt_pkg::*;

	logic [SKIP_W-1:0] skip_q;
	logic [SKIP_W-1:0] skip_n;
	logic              latch_q;
	logic              latch_d;

	// Latch a new press only once the release count has run out
	always_comb begin
		skip_n  = skip_q;
		latch_d = latch_q;
		if (skip_q == '0) begin
			if (down && !latch_q) begin
				latch_d = 1'b1;
				skip_n  = skip_cfg;
			end
		end else if (down) begin
			skip_n = skip_cfg;
		end else begin
			skip_n = skip_q - 1'b1;
		end
	end

	assign pressed = latch_d;

	// Advance on each accepted scan tick, drop the latch when consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q  <= '0;
			latch_q <= 1'b0;
		end else if (step) begin
			skip_q  <= skip_n;
			latch_q <= latch_d & ~take;
		end
	end

endmodule

FILE: src/crt_div.sv
// Restoring divider, one quotient bit per cycle, for count over scale.
module crt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  crt_pkg::div_req_t req,
	output crt_pkg::div_rsp_t rsp
);
	import crt_pkg::*;

	localparam int STEP_W = $clog2(CNT_W);

	logic [CNT_W-1:0]  quo_q;
	logic [7:0]        dvs_q;
	logic [7:0]        rem_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [8:0]        trial;
	logic              fits;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[CNT_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Hold the control state: busy while bits remain, done for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(CNT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load operands, then shift the quotient into the dividend register
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[CNT_W-2:0], fits};
			rem_q <= fits ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
